/* design/hwm_pkg.sv */
// Package for the holonomic wheel mixer: widths, register indexes, queue entry type
// and the arithmetic helper used by the back end. It depends on nothing else.
`timescale 1ns / 1ps

package hwm_pkg;

    localparam int DUTY_BITS  = 16;
    localparam int GAIN_W     = 16;
    localparam int GAIN_FRAC  = 12;
    localparam int SCALE_FRAC = 16;
    localparam int LIMIT_W    = DUTY_BITS - 1;
    localparam int PROD_W     = DUTY_BITS + GAIN_W;
    localparam int XS_W       = PROD_W - GAIN_FRAC;
    localparam int WHEEL_W    = XS_W + 1;
    localparam int MAG_W      = WHEEL_W - 1;
    localparam int MULP_W     = WHEEL_W + SCALE_FRAC + 1;
    localparam int CFG_W      = (GAIN_W > LIMIT_W) ? GAIN_W : LIMIT_W;
    localparam int CFG_IDX_W  = 2;
    localparam int STEP_W     = $clog2(SCALE_FRAC);
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int NUM_WHEELS = 4;

    localparam int WHEEL_FL = 0;
    localparam int WHEEL_FR = 1;
    localparam int WHEEL_BL = 2;
    localparam int WHEEL_BR = 3;

    localparam logic signed [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << GAIN_FRAC);
    localparam logic [LIMIT_W-1:0]       LIMIT_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STRAFE_GAIN  = 2'd0,
        REG_FORWARD_GAIN = 2'd1,
        REG_DUTY_LIMIT   = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KIND_PASS,
        KIND_SCALE,
        KIND_ERROR
    } kind_t;

    typedef logic signed [WHEEL_W-1:0] wheel_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] strafe_gain;
        logic signed [GAIN_W-1:0] forward_gain;
        logic [LIMIT_W-1:0]       duty_limit;
    } cfg_t;

    typedef struct packed {
        kind_t                         kind;
        logic [MAG_W-1:0]              biggest;
        logic [NUM_WHEELS-1:0][WHEEL_W-1:0] wheel;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    // Shift right by the scale fraction, rounding toward zero, and keep the duty width.
    function automatic logic signed [DUTY_BITS-1:0] scale_trunc(
        input logic signed [MULP_W-1:0] p
    );
        logic signed [MULP_W-1:0] adj;
        adj = p[MULP_W-1] ? (p + MULP_W'((1 << SCALE_FRAC) - 1)) : p;
        return adj[SCALE_FRAC+DUTY_BITS-1:SCALE_FRAC];
    endfunction

endpackage

/* design/hwm_if.sv */
// Handshake interfaces of the holonomic wheel mixer: body command in, wheel duties out.
// Widths come from hwm_pkg.
`timescale 1ns / 1ps

interface hwm_cmd_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [hwm_pkg::DUTY_BITS-1:0]   strafe_duty;
    logic signed [hwm_pkg::DUTY_BITS-1:0]   forward_duty;
    logic signed [hwm_pkg::DUTY_BITS-1:0]   yaw_duty;

    modport source (output valid, output strafe_duty, output forward_duty,
                    output yaw_duty, input ready);
    modport sink   (input valid, input strafe_duty, input forward_duty,
                    input yaw_duty, output ready);
endinterface

interface hwm_wheel_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [hwm_pkg::DUTY_BITS-1:0]   front_left;
    logic signed [hwm_pkg::DUTY_BITS-1:0]   front_right;
    logic signed [hwm_pkg::DUTY_BITS-1:0]   back_left;
    logic signed [hwm_pkg::DUTY_BITS-1:0]   back_right;
    logic                                   config_error;
    logic                                   was_scaled;

    modport source (output valid, output front_left, output front_right,
                    output back_left, output back_right, output config_error,
                    output was_scaled, input ready);
    modport sink   (input valid, input front_left, input front_right,
                    input back_left, input back_right, input config_error,
                    input was_scaled, output ready);
endinterface

/* design/hwm_front.sv */
// Front end of the wheel mixer: gain multiply, wheel sums and classification.
// Depends on hwm_pkg and hwm_cmd_if; pushes classified entries into hwm_queue.
`timescale 1ns / 1ps

module hwm_front (
    input  logic              clk,
    input  logic              rst_n,
    hwm_cmd_if.sink           command,
    input  hwm_pkg::cfg_t     cfg,
    input  hwm_pkg::qstat_t   qstat,
    output logic              push,
    output hwm_pkg::entry_t   push_entry
);

    logic                                  s1_valid_reg;
    logic                                  s1_valid_next;
    logic                                  s2_valid_reg;
    logic                                  s2_valid_next;
    logic signed [hwm_pkg::PROD_W-1:0]     prod_x_reg;
    logic signed [hwm_pkg::PROD_W-1:0]     prod_y_reg;
    logic signed [hwm_pkg::DUTY_BITS-1:0]  turn_reg;
    logic signed [hwm_pkg::PROD_W-1:0]     prod_x_next;
    logic signed [hwm_pkg::PROD_W-1:0]     prod_y_next;
    hwm_pkg::wheel_t                       wheel_reg  [hwm_pkg::NUM_WHEELS];
    hwm_pkg::wheel_t                       wheel_next [hwm_pkg::NUM_WHEELS];
    logic signed [hwm_pkg::XS_W-1:0]       xs;
    logic signed [hwm_pkg::XS_W-1:0]       ys;
    hwm_pkg::wheel_t                       xw;
    hwm_pkg::wheel_t                       yw;
    hwm_pkg::wheel_t                       rw;
    logic [hwm_pkg::MAG_W-1:0]             mag [hwm_pkg::NUM_WHEELS];
    logic [hwm_pkg::MAG_W-1:0]             max01;
    logic [hwm_pkg::MAG_W-1:0]             max23;
    logic [hwm_pkg::MAG_W-1:0]             biggest;
    logic                                  accept;
    logic                                  s1_move;
    logic                                  s2_room;

    assign s2_room       = !s2_valid_reg || !qstat.full;
    assign s1_move       = s1_valid_reg && s2_room;
    assign command.ready = !s1_valid_reg || s2_room;
    assign accept        = command.valid && command.ready;
    assign push          = s2_valid_reg && !qstat.full;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
        s2_valid_next = s2_valid_reg;
        if (s1_move)
        begin
            s2_valid_next = 1'b1;
        end
        else if (push)
        begin
            s2_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    assign prod_x_next = command.strafe_duty * cfg.strafe_gain;
    assign prod_y_next = command.forward_duty * cfg.forward_gain;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
            turn_reg   <= command.yaw_duty;
        end
    end

    // Dropping the low gain fraction bits of a signed product rounds toward minus infinity.
    assign xs = $signed(prod_x_reg[hwm_pkg::PROD_W-1:hwm_pkg::GAIN_FRAC]);
    assign ys = $signed(prod_y_reg[hwm_pkg::PROD_W-1:hwm_pkg::GAIN_FRAC]);
    assign xw = hwm_pkg::WHEEL_W'(xs);
    assign yw = hwm_pkg::WHEEL_W'(ys);
    assign rw = hwm_pkg::WHEEL_W'(turn_reg);

    always_comb
    begin
        wheel_next[hwm_pkg::WHEEL_FL] = yw + xw - rw;
        wheel_next[hwm_pkg::WHEEL_FR] = yw - xw + rw;
        wheel_next[hwm_pkg::WHEEL_BL] = yw - xw - rw;
        wheel_next[hwm_pkg::WHEEL_BR] = yw + xw + rw;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            wheel_reg <= wheel_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < hwm_pkg::NUM_WHEELS; i++)
        begin
            mag[i] = wheel_reg[i][hwm_pkg::WHEEL_W-1]
                   ? hwm_pkg::MAG_W'(-wheel_reg[i])
                   : hwm_pkg::MAG_W'(wheel_reg[i]);
        end
        max01   = (mag[0] > mag[1]) ? mag[0] : mag[1];
        max23   = (mag[2] > mag[3]) ? mag[2] : mag[3];
        biggest = (max01 > max23) ? max01 : max23;

        push_entry.biggest = biggest;
        for (int i = 0; i < hwm_pkg::NUM_WHEELS; i++)
        begin
            push_entry.wheel[i] = wheel_reg[i];
        end
        if (cfg.duty_limit == '0)
        begin
            push_entry.kind = hwm_pkg::KIND_ERROR;
        end
        else if (biggest > hwm_pkg::MAG_W'(cfg.duty_limit))
        begin
            push_entry.kind = hwm_pkg::KIND_SCALE;
        end
        else
        begin
            push_entry.kind = hwm_pkg::KIND_PASS;
        end
    end

endmodule

/* design/hwm_queue.sv */
// Short queue that decouples the mixer front end from the scaling back end.
// Depends on hwm_pkg for the entry type and depth.
`timescale 1ns / 1ps

module hwm_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  hwm_pkg::entry_t   push_entry,
    input  logic              pop,
    output hwm_pkg::entry_t   head,
    output hwm_pkg::qstat_t   qstat
);

    hwm_pkg::entry_t                 mem_reg [hwm_pkg::Q_DEPTH];
    logic [hwm_pkg::Q_PTR_W-1:0]     wr_ptr_reg;
    logic [hwm_pkg::Q_PTR_W-1:0]     wr_ptr_next;
    logic [hwm_pkg::Q_PTR_W-1:0]     rd_ptr_reg;
    logic [hwm_pkg::Q_PTR_W-1:0]     rd_ptr_next;
    logic [hwm_pkg::Q_PTR_W:0]       count_reg;
    logic [hwm_pkg::Q_PTR_W:0]       count_next;

    assign qstat.full  = (count_reg == (hwm_pkg::Q_PTR_W + 1)'(hwm_pkg::Q_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign head        = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* design/hwm_back.sv */
// Back end of the wheel mixer: scale divider, wheel scaling and the result register.
// Depends on hwm_pkg and hwm_wheel_if; pops entries from hwm_queue.
`timescale 1ns / 1ps

module hwm_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [hwm_pkg::LIMIT_W-1:0] duty_limit,
    input  hwm_pkg::entry_t             head,
    input  hwm_pkg::qstat_t             qstat,
    output logic                        pop,
    hwm_wheel_if.source                 wheels
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_OUT
    } state_t;

    state_t                                state_reg;
    state_t                                state_next;
    hwm_pkg::wheel_t                       wheel_reg  [hwm_pkg::NUM_WHEELS];
    hwm_pkg::wheel_t                       wheel_next [hwm_pkg::NUM_WHEELS];
    logic signed [hwm_pkg::MULP_W-1:0]     prod_reg   [hwm_pkg::NUM_WHEELS];
    logic signed [hwm_pkg::MULP_W-1:0]     prod_next  [hwm_pkg::NUM_WHEELS];
    logic signed [hwm_pkg::DUTY_BITS-1:0]  duty_reg   [hwm_pkg::NUM_WHEELS];
    logic signed [hwm_pkg::DUTY_BITS-1:0]  duty_next  [hwm_pkg::NUM_WHEELS];
    logic [hwm_pkg::MAG_W-1:0]             div_reg;
    logic [hwm_pkg::MAG_W-1:0]             div_next;
    logic [hwm_pkg::MAG_W-1:0]             rem_reg;
    logic [hwm_pkg::MAG_W-1:0]             rem_next;
    logic [hwm_pkg::SCALE_FRAC-1:0]        quo_reg;
    logic [hwm_pkg::SCALE_FRAC-1:0]        quo_next;
    logic [hwm_pkg::STEP_W-1:0]            step_reg;
    logic [hwm_pkg::STEP_W-1:0]            step_next;
    logic                                  out_valid_reg;
    logic                                  out_valid_next;
    logic                                  err_reg;
    logic                                  err_next;
    logic                                  scaled_reg;
    logic                                  scaled_next;
    logic [hwm_pkg::MAG_W:0]               trial;
    logic                                  fits;
    logic                                  out_free;

    assign out_free = !out_valid_reg || wheels.ready;
    assign trial    = {rem_reg, 1'b0};
    assign fits     = (trial >= {1'b0, div_reg});

    always_comb
    begin
        state_next     = state_reg;
        wheel_next     = wheel_reg;
        prod_next      = prod_reg;
        duty_next      = duty_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        err_next       = err_reg;
        scaled_next    = scaled_reg;
        out_valid_next = out_valid_reg && !wheels.ready;
        pop            = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!qstat.empty)
                begin
                    case (head.kind)
                        hwm_pkg::KIND_PASS:
                        begin
                            if (out_free)
                            begin
                                pop = 1'b1;
                                for (int i = 0; i < hwm_pkg::NUM_WHEELS; i++)
                                begin
                                    duty_next[i] = head.wheel[i][hwm_pkg::DUTY_BITS-1:0];
                                end
                                err_next       = 1'b0;
                                scaled_next    = 1'b0;
                                out_valid_next = 1'b1;
                            end
                        end
                        hwm_pkg::KIND_ERROR:
                        begin
                            if (out_free)
                            begin
                                pop = 1'b1;
                                for (int i = 0; i < hwm_pkg::NUM_WHEELS; i++)
                                begin
                                    duty_next[i] = '0;
                                end
                                err_next       = 1'b1;
                                scaled_next    = 1'b0;
                                out_valid_next = 1'b1;
                            end
                        end
                        hwm_pkg::KIND_SCALE:
                        begin
                            pop = 1'b1;
                            for (int i = 0; i < hwm_pkg::NUM_WHEELS; i++)
                            begin
                                wheel_next[i] = $signed(head.wheel[i]);
                            end
                            div_next   = head.biggest;
                            rem_next   = hwm_pkg::MAG_W'(duty_limit);
                            quo_next   = '0;
                            step_next  = hwm_pkg::STEP_W'(hwm_pkg::SCALE_FRAC - 1);
                            state_next = ST_DIV;
                        end
                        default:
                        begin
                            pop = 1'b0;
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                // The limit is below the divisor, so the quotient needs only the fraction bits.
                rem_next = fits ? hwm_pkg::MAG_W'(trial - {1'b0, div_reg})
                                : trial[hwm_pkg::MAG_W-1:0];
                quo_next = {quo_reg[hwm_pkg::SCALE_FRAC-2:0], fits};
                if (step_reg == '0)
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_MUL:
            begin
                for (int i = 0; i < hwm_pkg::NUM_WHEELS; i++)
                begin
                    prod_next[i] = wheel_reg[i] * $signed({1'b0, quo_reg});
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    for (int i = 0; i < hwm_pkg::NUM_WHEELS; i++)
                    begin
                        duty_next[i] = hwm_pkg::scale_trunc(prod_reg[i]);
                    end
                    err_next       = 1'b0;
                    scaled_next    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            err_reg       <= 1'b0;
            scaled_reg    <= 1'b0;
            div_reg       <= '0;
            rem_reg       <= '0;
            quo_reg       <= '0;
            step_reg      <= '0;
            for (int i = 0; i < hwm_pkg::NUM_WHEELS; i++)
            begin
                wheel_reg[i] <= '0;
                prod_reg[i]  <= '0;
                duty_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            err_reg       <= err_next;
            scaled_reg    <= scaled_next;
            div_reg       <= div_next;
            rem_reg       <= rem_next;
            quo_reg       <= quo_next;
            step_reg      <= step_next;
            wheel_reg     <= wheel_next;
            prod_reg      <= prod_next;
            duty_reg      <= duty_next;
        end
    end

    assign wheels.valid        = out_valid_reg;
    assign wheels.front_left   = duty_reg[hwm_pkg::WHEEL_FL];
    assign wheels.front_right  = duty_reg[hwm_pkg::WHEEL_FR];
    assign wheels.back_left    = duty_reg[hwm_pkg::WHEEL_BL];
    assign wheels.back_right   = duty_reg[hwm_pkg::WHEEL_BR];
    assign wheels.config_error = err_reg;
    assign wheels.was_scaled   = scaled_reg;

endmodule

/* design/holonomic_wheel_mixer.sv */
// Top level of the holonomic wheel mixer: configuration registers, front end, queue, back end.
// Depends on hwm_pkg, hwm_if, hwm_front, hwm_queue and hwm_back.
//
// Channel    Direction  Handshake            Contents
// command    in         valid/ready          strafe_duty, forward_duty, yaw_duty
// wheels     out        valid/ready          four wheel duties, config_error, was_scaled
// cfg        in         cfg_we, no ready     cfg_index, cfg_wdata
//
// Commands that need no scaling pass at one transaction per cycle while the wheels output is ready.
// A scaled command holds the back end through the bit-serial scale divider and the wheel multiply.
// A four-entry queue lets the front end keep taking transactions while the back end divides.
// Reset is asynchronous and restores unity gains and the largest duty limit.
`timescale 1ns / 1ps

module holonomic_wheel_mixer (
    input  logic                          clk,
    input  logic                          rst_n,
    hwm_cmd_if.sink                       command,
    hwm_wheel_if.source                   wheels,
    input  logic                          cfg_we,
    input  logic [hwm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hwm_pkg::CFG_W-1:0]     cfg_wdata
);

    hwm_pkg::cfg_t    cfg_reg;
    hwm_pkg::cfg_t    cfg_next;
    hwm_pkg::entry_t  push_entry;
    hwm_pkg::entry_t  head;
    hwm_pkg::qstat_t  qstat;
    logic             push;
    logic             pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                hwm_pkg::REG_STRAFE_GAIN:
                begin
                    cfg_next.strafe_gain = $signed(cfg_wdata[hwm_pkg::GAIN_W-1:0]);
                end
                hwm_pkg::REG_FORWARD_GAIN:
                begin
                    cfg_next.forward_gain = $signed(cfg_wdata[hwm_pkg::GAIN_W-1:0]);
                end
                hwm_pkg::REG_DUTY_LIMIT:
                begin
                    cfg_next.duty_limit = cfg_wdata[hwm_pkg::LIMIT_W-1:0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.strafe_gain  <= hwm_pkg::GAIN_ONE;
            cfg_reg.forward_gain <= hwm_pkg::GAIN_ONE;
            cfg_reg.duty_limit   <= hwm_pkg::LIMIT_MAX;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    hwm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .command    (command),
        .cfg        (cfg_reg),
        .qstat      (qstat),
        .push       (push),
        .push_entry (push_entry)
    );

    hwm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .qstat      (qstat)
    );

    hwm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .duty_limit (cfg_reg.duty_limit),
        .head       (head),
        .qstat      (qstat),
        .pop        (pop),
        .wheels     (wheels)
    );

endmodule
